[rtl/tmq_pkg.sv]
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared types and constants for the timed message queue.
// ----------------------------------------------------------------------------
package tmq_pkg;

    localparam int WORD_W      = 32;
    localparam int TAG_PORT_W  = 16;
    localparam int COUNT_OUT_W = 3;
    localparam int CMD_W       = 2;

    localparam int QUEUE_SLOTS_DEFAULT = 4;
    localparam int TAG_BITS_DEFAULT    = 16;

    localparam logic [WORD_W-1:0] DEFAULT_DURATION_RESET = 32'd800;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_POST    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISMISS = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [TAG_PORT_W-1:0] msg_tag;
        logic [WORD_W-1:0]     duration;
        logic [WORD_W-1:0]     now;
    } item_t;

    typedef struct packed {
        logic                   post_queued;
        logic                   changed;
        logic                   is_showing;
        logic [TAG_PORT_W-1:0]  shown_tag;
        logic [COUNT_OUT_W-1:0] queued_count;
        logic [COUNT_OUT_W-1:0] waiting_count;
        logic [WORD_W-1:0]      dropped_total;
        logic [WORD_W-1:0]      posted_total;
        logic [WORD_W-1:0]      expiry_tick;
    } result_t;

endpackage

[rtl/tmq_core.sv]
// ----------------------------------------------------------------------------
// tmq_core
// Queue state, default duration register and the per-command update logic.
// ----------------------------------------------------------------------------
module tmq_core #(
    parameter int QUEUE_SLOTS = tmq_pkg::QUEUE_SLOTS_DEFAULT,
    parameter int TAG_BITS    = tmq_pkg::TAG_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [tmq_pkg::WORD_W-1:0]  cfg_write_data,
    input  logic                        step,
    input  tmq_pkg::item_t              item,
    output tmq_pkg::result_t            result
);

    localparam int CNT_W      = $clog2(QUEUE_SLOTS + 1);
    localparam int SLOT_TAG_W = (TAG_BITS < tmq_pkg::TAG_PORT_W) ? TAG_BITS
                                                                 : tmq_pkg::TAG_PORT_W;

    logic [tmq_pkg::WORD_W-1:0] default_duration_reg;

    logic [SLOT_TAG_W-1:0]      slot_tag_reg      [QUEUE_SLOTS];
    logic [SLOT_TAG_W-1:0]      slot_tag_next     [QUEUE_SLOTS];
    logic [tmq_pkg::WORD_W-1:0] slot_duration_reg [QUEUE_SLOTS];
    logic [tmq_pkg::WORD_W-1:0] slot_duration_next[QUEUE_SLOTS];
    logic [CNT_W-1:0]           entry_count_reg, entry_count_next;
    logic                       head_visible_reg, head_visible_next;
    logic [tmq_pkg::WORD_W-1:0] retire_tick_reg, retire_tick_next;
    logic [tmq_pkg::WORD_W-1:0] drop_counter_reg, drop_counter_next;
    logic [tmq_pkg::WORD_W-1:0] post_counter_reg, post_counter_next;

    logic [tmq_pkg::WORD_W-1:0] dur_eff;
    logic [SLOT_TAG_W-1:0]      new_tag;
    logic [tmq_pkg::WORD_W-1:0] tick_diff;
    logic                       count_full;
    logic                       queued_ok;
    logic                       changed_flag;
    logic                       do_retire;
    logic [CNT_W-1:0]           waiting;
    logic [CNT_W+2:0]           count_ext;
    logic [CNT_W+2:0]           waiting_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_duration_reg <= tmq_pkg::DEFAULT_DURATION_RESET;
        end
        else if (cfg_write_en)
        begin
            default_duration_reg <= cfg_write_data;
        end
    end

    assign dur_eff    = (item.duration == '0) ? default_duration_reg : item.duration;
    assign new_tag    = item.msg_tag[SLOT_TAG_W-1:0];
    assign count_full = (entry_count_reg == CNT_W'(QUEUE_SLOTS));
    // wrap-safe compare: expired when now - retire_tick is non-negative
    assign tick_diff  = item.now - retire_tick_reg;

    always_comb
    begin
        slot_tag_next      = slot_tag_reg;
        slot_duration_next = slot_duration_reg;
        entry_count_next   = entry_count_reg;
        head_visible_next  = head_visible_reg;
        retire_tick_next   = retire_tick_reg;
        drop_counter_next  = drop_counter_reg;
        post_counter_next  = post_counter_reg;
        queued_ok          = 1'b0;
        changed_flag       = 1'b0;
        do_retire          = 1'b0;

        unique case (item.cmd)
            tmq_pkg::CMD_POST:
            begin
                post_counter_next = post_counter_reg + 32'd1;
                if (!count_full)
                begin
                    for (int i = 0; i < QUEUE_SLOTS; i++)
                    begin
                        if (CNT_W'(i) == entry_count_reg)
                        begin
                            slot_tag_next[i]      = new_tag;
                            slot_duration_next[i] = dur_eff;
                        end
                    end
                    entry_count_next = entry_count_reg + CNT_W'(1);
                    queued_ok        = 1'b1;
                end
                else
                begin
                    // full: drop the oldest waiting entry, the head stays
                    drop_counter_next = drop_counter_reg + 32'd1;
                    for (int i = 1; i < QUEUE_SLOTS - 1; i++)
                    begin
                        slot_tag_next[i]      = slot_tag_reg[i+1];
                        slot_duration_next[i] = slot_duration_reg[i+1];
                    end
                    slot_tag_next[QUEUE_SLOTS-1]      = new_tag;
                    slot_duration_next[QUEUE_SLOTS-1] = dur_eff;
                end
            end
            tmq_pkg::CMD_TICK:
            begin
                if (!head_visible_reg)
                begin
                    if (entry_count_reg != '0)
                    begin
                        head_visible_next = 1'b1;
                        retire_tick_next  = item.now + slot_duration_reg[0];
                        changed_flag      = 1'b1;
                    end
                end
                else if (!tick_diff[tmq_pkg::WORD_W-1])
                begin
                    do_retire    = 1'b1;
                    changed_flag = 1'b1;
                end
            end
            tmq_pkg::CMD_DISMISS:
            begin
                if (head_visible_reg)
                begin
                    do_retire    = 1'b1;
                    changed_flag = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (do_retire)
        begin
            for (int i = 0; i < QUEUE_SLOTS - 1; i++)
            begin
                slot_tag_next[i]      = slot_tag_reg[i+1];
                slot_duration_next[i] = slot_duration_reg[i+1];
            end
            slot_tag_next[QUEUE_SLOTS-1]      = '0;
            slot_duration_next[QUEUE_SLOTS-1] = '0;
            if (entry_count_reg != '0)
            begin
                entry_count_next = entry_count_reg - CNT_W'(1);
            end
            head_visible_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_SLOTS; i++)
            begin
                slot_tag_reg[i]      <= '0;
                slot_duration_reg[i] <= '0;
            end
            entry_count_reg  <= '0;
            head_visible_reg <= 1'b0;
            retire_tick_reg  <= '0;
            drop_counter_reg <= '0;
            post_counter_reg <= '0;
        end
        else if (step)
        begin
            slot_tag_reg      <= slot_tag_next;
            slot_duration_reg <= slot_duration_next;
            entry_count_reg   <= entry_count_next;
            head_visible_reg  <= head_visible_next;
            retire_tick_reg   <= retire_tick_next;
            drop_counter_reg  <= drop_counter_next;
            post_counter_reg  <= post_counter_next;
        end
    end

    // result reflects the state after this command
    assign waiting     = entry_count_next
                         - ((head_visible_next && entry_count_next != '0) ? CNT_W'(1)
                                                                          : CNT_W'(0));
    assign count_ext   = {3'b000, entry_count_next};
    assign waiting_ext = {3'b000, waiting};

    always_comb
    begin
        result.post_queued   = queued_ok;
        result.changed       = changed_flag;
        result.is_showing    = head_visible_next;
        result.shown_tag     = head_visible_next ? tmq_pkg::TAG_PORT_W'(slot_tag_next[0])
                                                 : '0;
        result.queued_count  = count_ext[tmq_pkg::COUNT_OUT_W-1:0];
        result.waiting_count = waiting_ext[tmq_pkg::COUNT_OUT_W-1:0];
        result.dropped_total = drop_counter_next;
        result.posted_total  = post_counter_next;
        result.expiry_tick   = retire_tick_next;
    end

    a_visible_needs_entry: assert property (
        @(posedge clk) disable iff (!rst_n)
        head_visible_reg |-> entry_count_reg != '0
    ) else $error("head shown with an empty queue");

    a_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(QUEUE_SLOTS)
    ) else $error("entry count above queue depth");

    a_post_counts: assert property (
        @(posedge clk) disable iff (!rst_n)
        step && item.cmd == tmq_pkg::CMD_POST
            |=> post_counter_reg == $past(post_counter_reg) + 32'd1
    ) else $error("post not counted");

    a_drop_only_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        step && !(item.cmd == tmq_pkg::CMD_POST && count_full)
            |=> drop_counter_reg == $past(drop_counter_reg)
    ) else $error("drop counted without a full-queue post");

endmodule

[rtl/timed_message_queue_top.sv]
// ----------------------------------------------------------------------------
// timed_message_queue_top
// Timed message queue with input register, single-pass update and result register.
// ----------------------------------------------------------------------------
// an accepted item waits in the input register until the result register is free,
// then passes the update and is captured in the result register
// throughput: one item per cycle unless stalled, limited by the single queue update
// reset: queue empty, nothing shown, counters zero, default duration 800
module timed_message_queue_top #(
    parameter int QUEUE_SLOTS = tmq_pkg::QUEUE_SLOTS_DEFAULT,
    parameter int TAG_BITS    = tmq_pkg::TAG_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_write_en,
    input  logic [tmq_pkg::WORD_W-1:0]       cfg_write_data,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tmq_pkg::CMD_W-1:0]        cmd,
    input  logic [tmq_pkg::TAG_PORT_W-1:0]   msg_tag,
    input  logic [tmq_pkg::WORD_W-1:0]       duration,
    input  logic [tmq_pkg::WORD_W-1:0]       now,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             post_queued,
    output logic                             changed,
    output logic                             is_showing,
    output logic [tmq_pkg::TAG_PORT_W-1:0]   shown_tag,
    output logic [tmq_pkg::COUNT_OUT_W-1:0]  queued_count,
    output logic [tmq_pkg::COUNT_OUT_W-1:0]  waiting_count,
    output logic [tmq_pkg::WORD_W-1:0]       dropped_total,
    output logic [tmq_pkg::WORD_W-1:0]       posted_total,
    output logic [tmq_pkg::WORD_W-1:0]       expiry_tick
);

    tmq_pkg::item_t   item_reg;
    logic             item_valid_reg, item_valid_next;
    tmq_pkg::result_t result_reg;
    tmq_pkg::result_t core_result;
    logic             out_valid_reg, out_valid_next;

    logic out_free;
    logic in_xfer;
    logic advance;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = item_valid_reg && out_free;
    assign in_stall = item_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;

    assign item_valid_next = in_xfer || (item_valid_reg && !advance);
    assign out_valid_next  = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.cmd      <= cmd;
            item_reg.msg_tag  <= msg_tag;
            item_reg.duration <= duration;
            item_reg.now      <= now;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    tmq_core #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .TAG_BITS    (TAG_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .step           (advance),
        .item           (item_reg),
        .result         (core_result)
    );

    assign out_valid     = out_valid_reg;
    assign post_queued   = result_reg.post_queued;
    assign changed       = result_reg.changed;
    assign is_showing    = result_reg.is_showing;
    assign shown_tag     = result_reg.shown_tag;
    assign queued_count  = result_reg.queued_count;
    assign waiting_count = result_reg.waiting_count;
    assign dropped_total = result_reg.dropped_total;
    assign posted_total  = result_reg.posted_total;
    assign expiry_tick   = result_reg.expiry_tick;

    a_stall_needs_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg && out_valid_reg
    ) else $error("input stalled with a free pipeline");

    a_advance_fills_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg
    ) else $error("processed item did not reach the result register");

    a_held_item_waits: assert property (
        @(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg)
    ) else $error("held item lost before processing");

endmodule
